### design/lsf_pkg.sv
// Shared constants, select codes and controller/datapath command types
// for the linear least-squares fit block. No dependencies.
package lsf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MIN_POINTS = 2;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = $clog2(MAX_POINTS);

    localparam int PT_W   = 16;
    localparam int OUT_W  = 32;
    localparam int STAT_W = 2;
    localparam int SX_W   = PT_W + CNT_W;
    localparam int SXX_W  = 2 * PT_W - 2 + CNT_W;
    localparam int SXY_W  = 2 * PT_W - 1 + CNT_W;

    // serial multiplier
    localparam int MOP_W  = SXY_W;
    localparam int MPRD_W = 2 * MOP_W;
    localparam int MCNT_W = $clog2(MOP_W);

    // restoring divider
    localparam int DIVN_W = 96;
    localparam int DIVD_W = 64;
    localparam int DCNT_W = $clog2(DIVN_W);

    // residual pass
    localparam int RES_W  = 42;
    localparam int RMAG_W = 41;
    localparam int RLO_W  = 32;
    localparam int RHI_W  = RMAG_W - RLO_W;
    localparam int ACC_W  = 2 * RMAG_W + CNT_W;

    // integer square root
    localparam int SQ_W    = 64;
    localparam int SQ_STEP = SQ_W / 2;
    localparam int SQCNT_W = $clog2(SQ_STEP);

    typedef logic [2:0] t_msel;
    localparam t_msel MSEL_N_SXX  = 3'd0;
    localparam t_msel MSEL_SX_SX  = 3'd1;
    localparam t_msel MSEL_N_SXY  = 3'd2;
    localparam t_msel MSEL_SX_SY  = 3'd3;
    localparam t_msel MSEL_SXX_SY = 3'd4;
    localparam t_msel MSEL_SX_SXY = 3'd5;

    typedef logic [1:0] t_dsel;
    localparam t_dsel DSEL_SLOPE = 2'd0;
    localparam t_dsel DSEL_ICPT  = 2'd1;
    localparam t_dsel DSEL_MEAN  = 2'd2;

    typedef logic [STAT_W-1:0] t_fit;
    localparam t_fit FIT_OK       = 2'd0;
    localparam t_fit FIT_FEW      = 2'd1;
    localparam t_fit FIT_ZERO_DEN = 2'd2;
    localparam t_fit FIT_DROPPED  = 2'd3;

    typedef struct packed {
        logic  load_pt;
        logic  mac;
        logic  mul_start;
        t_msel mul_sel;
        logic  div_start;
        t_dsel div_sel;
        logic  res_start;
        logic  sqrt_start;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic res_done;
        logic sqrt_done;
        logic few;
        logic den_bad;
        logic n_gt2;
    } t_stat;

endpackage

### design/lsf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lsf_pkg for widths.
module lsf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lsf_pkg::DIVN_W-1:0]  i_dividend,
    input  logic [lsf_pkg::DIVD_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [lsf_pkg::DIVN_W-1:0]  o_quotient
);
    import lsf_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVN_W-1:0] r_quo;
    logic [DIVD_W-1:0] r_dvs;
    logic [DIVD_W:0]   w_sh;
    logic [DIVD_W:0]   w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_quo[DIVN_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIVN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVD_W-1:0] : w_sh[DIVD_W-1:0];
            r_quo <= {r_quo[DIVN_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### design/lsf_dp.sv
// Datapath: point store, running sums, serial multiplier, residual pipeline,
// square root and result registers. Depends on lsf_pkg and lsf_div.
module lsf_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lsf_pkg::t_cmd                      i_cmd,
    input  logic signed [lsf_pkg::PT_W-1:0]    i_x_value,
    input  logic signed [lsf_pkg::PT_W-1:0]    i_y_value,
    output lsf_pkg::t_stat                     o_stat,
    output logic                               o_result_valid,
    output logic signed [lsf_pkg::OUT_W-1:0]   o_slope,
    output logic signed [lsf_pkg::OUT_W-1:0]   o_intercept,
    output logic [lsf_pkg::OUT_W-1:0]          o_rms_deviation,
    output logic [lsf_pkg::STAT_W-1:0]         o_fit_status
);
    import lsf_pkg::*;

    localparam int SLOPE_SH = 16;
    localparam int ICPT_SH  = 8;
    localparam int P_W      = OUT_W + PT_W;
    localparam int RV_N     = 6;

    // point store
    logic signed [PT_W-1:0] mem_x [MAX_POINTS];
    logic signed [PT_W-1:0] mem_y [MAX_POINTS];

    // accumulation
    logic                    r_keep;
    logic signed [PT_W-1:0]  r_px;
    logic signed [PT_W-1:0]  r_py;
    logic [CNT_W-1:0]        r_count;
    logic signed [SX_W-1:0]  r_sum_x;
    logic [SXX_W-1:0]        r_sum_xx;
    logic signed [SX_W-1:0]  r_sum_y;
    logic signed [SXY_W-1:0] r_sum_xy;
    logic                    r_ovf;
    logic signed [2*PT_W-1:0] w_xx;
    logic signed [2*PT_W-1:0] w_xy;

    // serial multiplier
    logic                     r_mbusy;
    logic                     r_mdone;
    logic [MCNT_W-1:0]        r_mcnt;
    logic [MPRD_W-1:0]        r_ma;
    logic [MOP_W-1:0]         r_mb;
    logic [MPRD_W-1:0]        r_mp;
    logic                     r_mneg;
    t_msel                    r_msel;
    logic signed [MOP_W-1:0]  w_opa;
    logic signed [MOP_W-1:0]  w_opb;
    logic signed [MPRD_W-1:0] w_mprod;
    logic signed [MPRD_W-1:0] r_den;
    logic signed [MPRD_W-1:0] r_num_a;
    logic signed [MPRD_W-1:0] r_num_b;

    // divider interface
    t_dsel                    r_dsel;
    logic                     r_dneg;
    logic [DIVN_W-1:0]        w_dvd;
    logic [DIVD_W-1:0]        w_dvs;
    logic                     w_dneg;
    logic                     w_ddone;
    logic [DIVN_W-1:0]        w_quo;
    logic [OUT_W-1:0]         w_sat;
    logic [MPRD_W-1:0]        w_mag_a;
    logic [MPRD_W-1:0]        w_mag_b;
    logic signed [OUT_W-1:0]  r_slope;
    logic signed [OUT_W-1:0]  r_icpt;
    logic [DIVN_W-1:0]        r_mean;

    // residual pipeline
    logic                     r_rbusy;
    logic                     r_rrun;
    logic                     r_rdone;
    logic [CNT_W-1:0]         r_ridx;
    logic [RV_N-1:0]          r_rv;
    logic signed [PT_W-1:0]   r_rdx;
    logic signed [PT_W-1:0]   r_rdy;
    logic signed [P_W-1:0]    r_p;
    logic signed [PT_W-1:0]   r_y2;
    logic signed [RES_W-1:0]  w_r;
    logic [RMAG_W-1:0]        r_rmag;
    logic [2*RLO_W-1:0]       r_ll;
    logic [2*RLO_W-1:0]       r_ll5;
    logic [2*RLO_W-1:0]       r_ll6;
    logic [RHI_W-1:0]         r_hi4;
    logic [RLO_W-1:0]         r_lo4;
    logic [RHI_W-1:0]         r_hi5;
    logic [RHI_W+RLO_W-1:0]   r_lh;
    logic [RHI_W+RLO_W-1:0]   r_lh6;
    logic [2*RHI_W-1:0]       r_hh;
    logic [ACC_W-1:0]         r_acc;

    // square root
    logic                     r_sbusy;
    logic                     r_sdone;
    logic [SQCNT_W-1:0]       r_scnt;
    logic [SQ_W-1:0]          r_sv;
    logic [SQ_W-1:0]          r_sres;
    logic [SQ_W-1:0]          r_sbit;
    logic                     r_shi;
    logic [SQ_W-1:0]          w_trial;
    logic [OUT_W-1:0]         w_rms;

    logic                     w_few;
    logic                     w_den_bad;
    logic                     w_n_gt2;
    logic                     w_issue;

    assign w_xx = r_px * r_px;
    assign w_xy = r_px * r_py;

    assign w_few     = (r_count < CNT_W'(MIN_POINTS));
    assign w_n_gt2   = (r_count > CNT_W'(MIN_POINTS));
    assign w_den_bad = r_den[MPRD_W-1] || (r_den == '0);

    // multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            MSEL_N_SXX: begin
                w_opa = MOP_W'(r_count);
                w_opb = MOP_W'(r_sum_xx);
            end
            MSEL_SX_SX: begin
                w_opa = MOP_W'(r_sum_x);
                w_opb = MOP_W'(r_sum_x);
            end
            MSEL_N_SXY: begin
                w_opa = MOP_W'(r_count);
                w_opb = r_sum_xy;
            end
            MSEL_SX_SY: begin
                w_opa = MOP_W'(r_sum_x);
                w_opb = MOP_W'(r_sum_y);
            end
            MSEL_SXX_SY: begin
                w_opa = MOP_W'(r_sum_xx);
                w_opb = MOP_W'(r_sum_y);
            end
            MSEL_SX_SXY: begin
                w_opa = MOP_W'(r_sum_x);
                w_opb = r_sum_xy;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_mprod = r_mneg ? -$signed(r_mp) : $signed(r_mp);

    // divider operands
    assign w_mag_a = r_num_a[MPRD_W-1] ? MPRD_W'(-r_num_a) : MPRD_W'(r_num_a);
    assign w_mag_b = r_num_b[MPRD_W-1] ? MPRD_W'(-r_num_b) : MPRD_W'(r_num_b);

    always_comb begin
        unique case (i_cmd.div_sel)
            DSEL_SLOPE: begin
                w_dvd  = DIVN_W'(w_mag_a) << SLOPE_SH;
                w_dvs  = DIVD_W'(r_den);
                w_dneg = r_num_a[MPRD_W-1];
            end
            DSEL_ICPT: begin
                w_dvd  = DIVN_W'(w_mag_b) << ICPT_SH;
                w_dvs  = DIVD_W'(r_den);
                w_dneg = r_num_b[MPRD_W-1];
            end
            DSEL_MEAN: begin
                w_dvd  = DIVN_W'(r_acc);
                w_dvs  = DIVD_W'(r_count);
                w_dneg = 1'b0;
            end
            default: begin
                w_dvd  = '0;
                w_dvs  = '0;
                w_dneg = 1'b0;
            end
        endcase
    end

    lsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_ddone),
        .o_quotient (w_quo)
    );

    // saturate the quotient magnitude into signed 32 bits
    always_comb begin
        if (r_dneg) begin
            if (w_quo > DIVN_W'(64'h8000_0000)) begin
                w_sat = 32'h8000_0000;
            end else begin
                w_sat = 32'h0 - w_quo[OUT_W-1:0];
            end
        end else begin
            if (w_quo > DIVN_W'(64'h7FFF_FFFF)) begin
                w_sat = 32'h7FFF_FFFF;
            end else begin
                w_sat = w_quo[OUT_W-1:0];
            end
        end
    end

    assign w_issue = r_rrun;
    assign w_r = RES_W'($signed({r_y2, 8'h00})) - RES_W'(r_p >>> 8) - RES_W'(r_icpt);

    assign w_trial = r_sres + r_sbit;
    assign w_rms   = r_shi ? {OUT_W{1'b1}} : r_sres[OUT_W-1:0];

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt && (r_count < CNT_W'(MAX_POINTS))) begin
            mem_x[r_count[ADDR_W-1:0]] <= i_x_value;
            mem_y[r_count[ADDR_W-1:0]] <= i_y_value;
        end
        if (w_issue) begin
            r_rdx <= mem_x[r_ridx[ADDR_W-1:0]];
            r_rdy <= mem_y[r_ridx[ADDR_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_sum_x        <= '0;
            r_sum_xx       <= '0;
            r_sum_y        <= '0;
            r_sum_xy       <= '0;
            r_ovf          <= 1'b0;
            r_mbusy        <= 1'b0;
            r_mdone        <= 1'b0;
            r_mcnt         <= '0;
            r_rbusy        <= 1'b0;
            r_rrun         <= 1'b0;
            r_rdone        <= 1'b0;
            r_ridx         <= '0;
            r_rv           <= '0;
            r_sbusy        <= 1'b0;
            r_sdone        <= 1'b0;
            r_scnt         <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_mdone        <= 1'b0;
            r_rdone        <= 1'b0;
            r_sdone        <= 1'b0;
            o_result_valid <= i_cmd.emit;

            if (i_cmd.mac) begin
                if (r_keep) begin
                    r_count  <= r_count + 1'b1;
                    r_sum_x  <= r_sum_x + SX_W'(r_px);
                    r_sum_xx <= r_sum_xx + SXX_W'($unsigned(w_xx));
                    r_sum_y  <= r_sum_y + SX_W'(r_py);
                    r_sum_xy <= r_sum_xy + SXY_W'(w_xy);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == MCNT_W'(MOP_W - 1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end

            r_rv <= {r_rv[RV_N-2:0], w_issue};
            if (i_cmd.res_start) begin
                r_rbusy <= 1'b1;
                r_rrun  <= 1'b1;
                r_ridx  <= '0;
            end else begin
                if (w_issue) begin
                    r_ridx <= r_ridx + 1'b1;
                    if ((r_ridx + 1'b1) == r_count) begin
                        r_rrun <= 1'b0;
                    end
                end
                if (r_rbusy && !r_rrun && (r_rv == '0)) begin
                    r_rbusy <= 1'b0;
                    r_rdone <= 1'b1;
                end
            end

            if (i_cmd.sqrt_start) begin
                r_sbusy <= 1'b1;
                r_scnt  <= '0;
            end else if (r_sbusy) begin
                r_scnt <= r_scnt + 1'b1;
                if (r_scnt == SQCNT_W'(SQ_STEP - 1)) begin
                    r_sbusy <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end

            // drop the closed set
            if (i_cmd.emit) begin
                r_count  <= '0;
                r_sum_x  <= '0;
                r_sum_xx <= '0;
                r_sum_y  <= '0;
                r_sum_xy <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_px   <= i_x_value;
            r_py   <= i_y_value;
            r_keep <= (r_count < CNT_W'(MAX_POINTS));
        end

        if (i_cmd.mul_start) begin
            r_ma   <= MPRD_W'(w_opa[MOP_W-1] ? MOP_W'(-w_opa) : MOP_W'(w_opa));
            r_mb   <= w_opb[MOP_W-1] ? MOP_W'(-w_opb) : MOP_W'(w_opb);
            r_mp   <= '0;
            r_mneg <= w_opa[MOP_W-1] ^ w_opb[MOP_W-1];
            r_msel <= i_cmd.mul_sel;
        end else if (r_mbusy) begin
            if (r_mb[0]) begin
                r_mp <= r_mp + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end

        if (r_mdone) begin
            unique case (r_msel)
                MSEL_N_SXX:  r_den   <= w_mprod;
                MSEL_SX_SX:  r_den   <= r_den - w_mprod;
                MSEL_N_SXY:  r_num_a <= w_mprod;
                MSEL_SX_SY:  r_num_a <= r_num_a - w_mprod;
                MSEL_SXX_SY: r_num_b <= w_mprod;
                MSEL_SX_SXY: r_num_b <= r_num_b - w_mprod;
                default: ;
            endcase
        end

        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
            r_dneg <= w_dneg;
        end
        if (w_ddone) begin
            unique case (r_dsel)
                DSEL_SLOPE: r_slope <= w_sat;
                DSEL_ICPT:  r_icpt  <= w_sat;
                DSEL_MEAN:  r_mean  <= w_quo;
                default: ;
            endcase
        end

        // residual stages: slope*x, residual, then r^2 in three partial products
        r_p    <= P_W'(r_slope) * P_W'(r_rdx);
        r_y2   <= r_rdy;
        r_rmag <= w_r[RES_W-1] ? RMAG_W'(-w_r) : RMAG_W'(w_r);
        r_ll   <= (2*RLO_W)'(r_rmag[RLO_W-1:0]) * (2*RLO_W)'(r_rmag[RLO_W-1:0]);
        r_hi4  <= r_rmag[RMAG_W-1:RLO_W];
        r_lo4  <= r_rmag[RLO_W-1:0];
        r_lh   <= (RHI_W+RLO_W)'(r_hi4) * (RHI_W+RLO_W)'(r_lo4);
        r_ll5  <= r_ll;
        r_hi5  <= r_hi4;
        r_hh   <= (2*RHI_W)'(r_hi5) * (2*RHI_W)'(r_hi5);
        r_ll6  <= r_ll5;
        r_lh6  <= r_lh;

        if (i_cmd.res_start) begin
            r_acc <= '0;
        end else if (r_rv[RV_N-1]) begin
            r_acc <= r_acc + ACC_W'(r_ll6) + (ACC_W'(r_lh6) << (RLO_W + 1))
                     + (ACC_W'(r_hh) << (2 * RLO_W));
        end

        if (i_cmd.sqrt_start) begin
            r_sv   <= r_mean[SQ_W-1:0];
            r_sres <= '0;
            r_sbit <= SQ_W'(1) << (SQ_W - 2);
            r_shi  <= |r_mean[DIVN_W-1:SQ_W];
        end else if (r_sbusy) begin
            if (r_sv >= w_trial) begin
                r_sv   <= r_sv - w_trial;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end

        if (i_cmd.emit) begin
            priority if (w_few) begin
                o_slope         <= '0;
                o_intercept     <= '0;
                o_rms_deviation <= '0;
                o_fit_status    <= FIT_FEW;
            end else if (w_den_bad) begin
                o_slope         <= '0;
                o_intercept     <= '0;
                o_rms_deviation <= '0;
                o_fit_status    <= FIT_ZERO_DEN;
            end else begin
                o_slope         <= r_slope;
                o_intercept     <= r_icpt;
                o_rms_deviation <= w_n_gt2 ? w_rms : '0;
                o_fit_status    <= r_ovf ? FIT_DROPPED : FIT_OK;
            end
        end
    end

    assign o_stat.mul_done  = r_mdone;
    assign o_stat.div_done  = w_ddone;
    assign o_stat.res_done  = r_rdone;
    assign o_stat.sqrt_done = r_sdone;
    assign o_stat.few       = w_few;
    assign o_stat.den_bad   = w_den_bad;
    assign o_stat.n_gt2     = w_n_gt2;

endmodule

### design/lsf_ctrl.sv
// Controller state machine: sequences point loading, the six products,
// the divisions, the residual pass and the square root. Depends on lsf_pkg.
module lsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_point,
    input  lsf_pkg::t_stat i_stat,
    output lsf_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import lsf_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MAC       = 4'd1;
    localparam logic [3:0] S_MUL_GO    = 4'd2;
    localparam logic [3:0] S_MUL_WAIT  = 4'd3;
    localparam logic [3:0] S_CHECK     = 4'd4;
    localparam logic [3:0] S_DIV_GO    = 4'd5;
    localparam logic [3:0] S_DIV_WAIT  = 4'd6;
    localparam logic [3:0] S_RES_GO    = 4'd7;
    localparam logic [3:0] S_RES_WAIT  = 4'd8;
    localparam logic [3:0] S_SQRT_GO   = 4'd9;
    localparam logic [3:0] S_SQRT_WAIT = 4'd10;
    localparam logic [3:0] S_EMIT      = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_msel      r_msel;
    t_msel      n_msel;
    t_dsel      r_dsel;
    t_dsel      n_dsel;
    logic       r_last;
    logic       n_last;

    always_comb begin
        n_state = r_state;
        n_msel  = r_msel;
        n_dsel  = r_dsel;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.mul_sel = r_msel;
        o_cmd.div_sel = r_dsel;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_pt = 1'b1;
                    n_last  = i_last_point;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_last) begin
                    n_msel  = MSEL_N_SXX;
                    n_state = S_MUL_GO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (i_stat.mul_done) begin
                    if (r_msel == MSEL_SX_SXY) begin
                        n_state = S_CHECK;
                    end else begin
                        n_msel  = t_msel'(r_msel + 1'b1);
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.few || i_stat.den_bad) begin
                    n_state = S_EMIT;
                end else begin
                    n_dsel  = DSEL_SLOPE;
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    priority if (r_dsel == DSEL_SLOPE) begin
                        n_dsel  = DSEL_ICPT;
                        n_state = S_DIV_GO;
                    end else if (r_dsel == DSEL_ICPT) begin
                        n_state = i_stat.n_gt2 ? S_RES_GO : S_EMIT;
                    end else begin
                        n_state = S_SQRT_GO;
                    end
                end
            end
            S_RES_GO: begin
                o_cmd.res_start = 1'b1;
                n_state = S_RES_WAIT;
            end
            S_RES_WAIT: begin
                if (i_stat.res_done) begin
                    n_dsel  = DSEL_MEAN;
                    n_state = S_DIV_GO;
                end
            end
            S_SQRT_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_msel  <= MSEL_N_SXX;
            r_dsel  <= DSEL_SLOPE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_msel  <= n_msel;
            r_dsel  <= n_dsel;
            r_last  <= n_last;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### design/linear_least_squares_fit_top.sv
// Top level of the linear least-squares fit: controller plus datapath.
// Depends on lsf_pkg, lsf_ctrl, lsf_dp (and lsf_div below it).
//
// Usage:
//   Drive one (x, y) point in signed Q8.8 with start high; it transfers on a
//   rising edge where start is high and busy is low. Each point is accepted,
//   then accumulated while busy is high, and only then can the next point
//   transfer. Up to 1024 points are kept; later points of the same set are
//   dropped and flagged. The point with last_point set closes the set. The
//   fit then runs six serial products; then, unless the set is too small or
//   the denominator is not positive, two divisions and, for more than two
//   points, a residual pass over the store, a third division and a square
//   root, after which the result is emitted.
//   The result (slope, intercept, rms deviation, status) is on the output
//   ports for exactly one cycle with o_result_valid high; the receiver
//   cannot stall, so take it then. busy falls as the result is shown.
//   Reset (synchronous, active low) empties the point set and returns the
//   controller to idle; the store needs no clearing.
module linear_least_squares_fit_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [lsf_pkg::PT_W-1:0]   i_x_value,
    input  logic signed [lsf_pkg::PT_W-1:0]   i_y_value,
    input  logic                              i_last_point,
    output logic                              o_result_valid,
    output logic signed [lsf_pkg::OUT_W-1:0]  o_slope,
    output logic signed [lsf_pkg::OUT_W-1:0]  o_intercept,
    output logic [lsf_pkg::OUT_W-1:0]         o_rms_deviation,
    output logic [lsf_pkg::STAT_W-1:0]        o_fit_status
);
    import lsf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    lsf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_point (i_last_point),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (busy)
    );

    lsf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_x_value       (i_x_value),
        .i_y_value       (i_y_value),
        .o_stat          (w_stat),
        .o_result_valid  (o_result_valid),
        .o_slope         (o_slope),
        .o_intercept     (o_intercept),
        .o_rms_deviation (o_rms_deviation),
        .o_fit_status    (o_fit_status)
    );

    a_accept_busy: assert property (@(posedge i_clk)
        (i_rst_n && start && !busy) |=> busy)
        else $error("accepted point did not raise busy");

    a_emit_strobe: assert property (@(posedge i_clk)
        (i_rst_n && w_cmd.emit) |=> o_result_valid)
        else $error("emit did not produce a result strobe");

    a_single_strobe: assert property (@(posedge i_clk)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_err_zero: assert property (@(posedge i_clk)
        (o_result_valid && (o_fit_status == FIT_FEW || o_fit_status == FIT_ZERO_DEN))
        |-> (o_slope == '0 && o_intercept == '0 && o_rms_deviation == '0))
        else $error("failed fit reported nonzero values");

endmodule

### sim/tb_linear_least_squares_fit_top.sv
// Self-checking testbench for linear_least_squares_fit_top: streams point sets,
// predicts slope, intercept, rms deviation and status, and checks each result.
// Depends on lsf_pkg and the design files under design/.
module tb_linear_least_squares_fit_top;
    import lsf_pkg::*;

    typedef struct {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic                   last;
        logic                   hold;
    } t_point;

    typedef struct {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] icpt;
        logic [OUT_W-1:0]        rms;
        t_fit                    status;
    } t_fit_result;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [PT_W-1:0]  i_x_value;
    logic signed [PT_W-1:0]  i_y_value;
    logic                    i_last_point;
    logic                    o_result_valid;
    logic signed [OUT_W-1:0] o_slope;
    logic signed [OUT_W-1:0] o_intercept;
    logic [OUT_W-1:0]        o_rms_deviation;
    logic [STAT_W-1:0]       o_fit_status;

    linear_least_squares_fit_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_x_value       (i_x_value),
        .i_y_value       (i_y_value),
        .i_last_point    (i_last_point),
        .o_result_valid  (o_result_valid),
        .o_slope         (o_slope),
        .o_intercept     (o_intercept),
        .o_rms_deviation (o_rms_deviation),
        .o_fit_status    (o_fit_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic signed [PT_W-1:0] set_x [MAX_POINTS];
    logic signed [PT_W-1:0] set_y [MAX_POINTS];
    int unsigned            set_count;
    logic signed [63:0]     acc_x, acc_xx, acc_y, acc_xy;
    logic                   set_dropped;

    t_point      point_q [$];
    t_fit_result fit_expect_q [$];
    int          err_count;
    int          points_sent;
    int          results_seen;
    int          status_seen [4];
    int          cycle_count;
    int          quiet_cycles;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $time, what);
        err_count++;
    endtask

    function automatic logic signed [OUT_W-1:0] sat_quotient(
        input logic signed [127:0] num, input int shift, input logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< shift) / den;
        if (q > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (q < -128'sh8000_0000) return 32'sh8000_0000;
        return q[31:0];
    endfunction

    function automatic logic [31:0] root_floor(input logic [63:0] v);
        logic [63:0] res, bt, rem;
        res = '0;
        bt  = 64'h1 << 62;
        rem = v;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res[31:0];
    endfunction

    task automatic clear_set();
        set_count   = 0;
        acc_x       = '0;
        acc_xx      = '0;
        acc_y       = '0;
        acc_xy      = '0;
        set_dropped = 1'b0;
    endtask

    // Add one transferred point; on the closing point, predict the fit.
    task automatic fit_point(input logic signed [PT_W-1:0] x,
                             input logic signed [PT_W-1:0] y, input logic last);
        logic signed [127:0] n, sxx, sx, sy, sxy, den, p, r, acc, mean;
        t_fit_result res;
        if (set_count < MAX_POINTS) begin
            set_x[set_count] = x;
            set_y[set_count] = y;
            set_count++;
            acc_x  += x;
            acc_xx += x * x;
            acc_y  += y;
            acc_xy += x * y;
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) return;
        n   = set_count;
        sx  = acc_x;
        sxx = acc_xx;
        sy  = acc_y;
        sxy = acc_xy;
        den = n * sxx - sx * sx;
        res.slope = '0;
        res.icpt  = '0;
        res.rms   = '0;
        if (set_count < MIN_POINTS) begin
            res.status = FIT_FEW;
        end else if (den <= 0) begin
            res.status = FIT_ZERO_DEN;
        end else begin
            res.slope = sat_quotient(n * sxy - sx * sy, 16, den);
            res.icpt  = sat_quotient(sxx * sy - sx * sxy, 8, den);
            if (set_count > 2) begin
                acc = '0;
                for (int k = 0; k < set_count; k++) begin
                    p = 128'(res.slope) * 128'(set_x[k]);
                    r = 128'(set_y[k]) * 256 - (p >>> 8) - 128'(res.icpt);
                    acc += r * r;
                end
                mean = acc / n;
                res.rms = (mean[127:64] != 0) ? 32'hFFFF_FFFF : root_floor(mean[63:0]);
            end
            res.status = set_dropped ? FIT_DROPPED : FIT_OK;
        end
        fit_expect_q.push_back(res);
        clear_set();
    endtask

    // driver
    logic   transfer;
    logic   next_start;
    t_point cur;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        transfer = start && !busy;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_x_value    <= '0;
            i_y_value    <= '0;
            i_last_point <= 1'b0;
        end else begin
            if (transfer) begin
                fit_point(i_x_value, i_y_value, i_last_point);
                points_sent++;
            end
            next_start = start && !transfer;
            if ((!start || transfer) && point_q.size() > 0) begin
                // idle at random, except in a calm stretch
                if ((cycle_count >= 3000 && cycle_count < 9000) ||
                    $urandom_range(0, 99) >= 15) begin
                    if (!point_q[0].hold || (fit_expect_q.size() == 0 && !busy)) begin
                        cur = point_q.pop_front();
                        i_x_value    <= cur.x;
                        i_y_value    <= cur.y;
                        i_last_point <= cur.last;
                        next_start = 1'b1;
                    end
                end
            end
            start <= next_start;
        end
    end

    // monitor
    t_fit_result want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (fit_expect_q.size() == 0) begin
                report("result with no fit pending");
            end else begin
                want = fit_expect_q.pop_front();
                status_seen[want.status]++;
                if (o_slope !== want.slope)
                    report($sformatf("slope %h, want %h", o_slope, want.slope));
                if (o_intercept !== want.icpt)
                    report($sformatf("intercept %h, want %h", o_intercept, want.icpt));
                if (o_rms_deviation !== want.rms)
                    report($sformatf("rms %h, want %h", o_rms_deviation, want.rms));
                if (o_fit_status !== want.status)
                    report($sformatf("status %0d, want %0d", o_fit_status, want.status));
            end
        end
    end

    // watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d fits pending", fit_expect_q.size());
            $display("tb_linear_least_squares_fit_top: errors");
            $finish;
        end
    end

    task automatic add_point(input int x, input int y, input bit last, input bit hold);
        t_point pt;
        pt.x    = x[PT_W-1:0];
        pt.y    = y[PT_W-1:0];
        pt.last = last;
        pt.hold = hold;
        point_q.push_back(pt);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(0, 15) - 8;
            default: return int'($signed(16'($urandom_range(0, 65535))));
        endcase
    endfunction

    task automatic add_set(input int size, input bit same_x, input bit hold);
        int x0;
        x0 = rand_coord();
        for (int k = 0; k < size; k++)
            add_point(same_x ? x0 : rand_coord(), rand_coord(), k == size - 1,
                      hold && k == 0);
    endtask

    int queued;
    int size;
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_x_value    = '0;
        i_y_value    = '0;
        i_last_point = 1'b0;
        err_count    = 0;
        points_sent  = 0;
        results_seen = 0;
        cycle_count  = 0;
        quiet_cycles = 0;
        status_seen  = '{default: 0};
        clear_set();

        // directed: lone point, extreme pair, vertical line, steep slope and two further small sets
        add_point(-32768, 32767, 1, 0);
        add_point(-32768, -32768, 0, 0);
        add_point(32767, 32767, 1, 0);
        add_point(32767, -32768, 0, 0);
        add_point(32767, 32767, 0, 0);
        add_point(32767, 0, 1, 0);
        add_point(0, -32768, 0, 0);
        add_point(1, 32767, 0, 0);
        add_point(0, 32767, 1, 0);
        add_point(-32768, 0, 0, 1);
        add_point(32767, -1, 0, 0);
        add_point(256, 512, 0, 0);
        add_point(-256, -512, 0, 0);
        add_point(1000, 77, 1, 0);
        add_point(-1, 0, 0, 0);
        add_point(1, 0, 0, 0);
        add_point(0, 1, 1, 0);
        // overfull set: the last six points drop
        add_set(MAX_POINTS + 6, 0, 1);
        queued = 0;
        while (queued < 450) begin
            case ($urandom_range(0, 19))
                0:       size = 1;
                1, 2:    size = $urandom_range(2, 6);
                default: size = $urandom_range(2, 14);
            endcase
            add_set(size, $urandom_range(0, 14) == 0, $urandom_range(0, 9) == 0);
            queued += size;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (point_q.size() > 0 || start) @(posedge i_clk);
        while (fit_expect_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("sent %0d points, checked %0d fits", points_sent, results_seen);
        $display("fits by status: ok %0d, few %0d, zero den %0d, dropped %0d",
                 status_seen[FIT_OK], status_seen[FIT_FEW],
                 status_seen[FIT_ZERO_DEN], status_seen[FIT_DROPPED]);
        if (err_count == 0 && fit_expect_q.size() == 0)
            $display("tb_linear_least_squares_fit_top: clean");
        else
            $display("tb_linear_least_squares_fit_top: errors");
        $finish;
    end
endmodule

### filelist.f
design/lsf_pkg.sv
design/lsf_div.sv
design/lsf_dp.sv
design/lsf_ctrl.sv
design/linear_least_squares_fit_top.sv
sim/tb_linear_least_squares_fit_top.sv
